@@ hdl/pat_pkg.sv @@
`timescale 1ns / 1ps

package pat_pkg;

  localparam int unsigned PendDepth = 32;
  localparam int unsigned PendIdxW  = $clog2(PendDepth);
  localparam int unsigned PendCntW  = PendIdxW + 1;
  localparam int unsigned SeqW      = 16;
  localparam int unsigned AckWin    = 32;
  localparam int unsigned WinIdxW   = $clog2(AckWin);
  localparam int unsigned MissW     = 8;
  localparam int unsigned DlW       = 32;
  localparam int unsigned NowW      = 31;
  localparam int unsigned TmoW      = 16;

  localparam logic [1:0] OP_SENT = 2'd0;
  localparam logic [1:0] OP_RECV = 2'd1;
  localparam logic [1:0] OP_ACK  = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_ACKED = 2'd1;
  localparam logic [1:0] EV_LOST  = 2'd2;
  localparam logic [1:0] EV_FULL  = 2'd3;

  localparam logic [SeqW-1:0] SeqHalf = SeqW'(1) << (SeqW - 1);

  typedef struct packed {
    logic [SeqW-1:0]  seq;
    logic [MissW-1:0] misses;
    logic [DlW-1:0]   deadline;
  } pend_entry_t;

  // a newer than b, modulo wrap; exact half range favors the larger value
  function automatic logic seq_newer(input logic [SeqW-1:0] a, input logic [SeqW-1:0] b);
    logic [SeqW-1:0] d;
    d = a - b;
    return (d != '0) && ((d < SeqHalf) || ((d == SeqHalf) && (a > b)));
  endfunction

endpackage

@@ hdl/packet_ack_tracker_top.sv @@
`timescale 1ns / 1ps

// Reliability bookkeeping for a sequenced link. Sent packets wait in a 32-entry
// table held in one synchronous memory (circular, oldest first); received remote
// sequences fold into a 32-bit window. Sent and received items each give one beat.
// Ack walks all pending entries, each with a memory read, then evaluate and
// compacting write-back; tick walks expired entries from the oldest until a live
// entry ends the walk or the table runs empty. Output stalls hold the walk. The
// block takes a new item only when idle and the output register can accept.
module packet_ack_tracker_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // now_time[30:0], ack_tmo[46:31], sequence_in[62:47], ack_bits_in[94:63]
  input  logic [95:0]  s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // event_seq[15:0], remote_ack_seq[31:16], remote_ack_bits[63:32],
  // remote_ack_valid[64]
  output logic [71:0]  m_axis_tdata,
  // event_kind[1:0]
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import pat_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RD   = 2'd1;
  localparam logic [1:0] ST_EV   = 2'd2;
  localparam logic [1:0] ST_END  = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [7:0]          thr_q;
  logic [SeqW-1:0]     next_seq_q, next_seq_d;
  logic [PendIdxW-1:0] head_q, head_d;
  logic [PendCntW-1:0] cnt_q, cnt_d;
  logic [PendCntW-1:0] r_q, r_d, w_q, w_d;
  logic [1:0]          op_q;
  logic [NowW-1:0]     now_q;
  logic [SeqW-1:0]     sq_q;
  logic [AckWin-1:0]   bits_q;

  logic [SeqW-1:0]     nrs_q, nrs_d;
  logic [AckWin-1:0]   win_q, win_d;
  logic                seen_q, seen_d;

  logic                ov_q;
  logic [1:0]          okind_q;
  logic [SeqW-1:0]     oseq_q, oremseq_q;
  logic                olast_q, oremvalid_q;
  logic [AckWin-1:0]   orembits_q;

  pend_entry_t         mem [PendDepth];
  pend_entry_t         rd_q, wdata;
  logic                we;
  logic [PendIdxW-1:0] waddr, raddr;

  logic       accept, out_free, emit;
  logic [1:0] emit_kind;
  logic [SeqW-1:0] emit_seq;
  logic       emit_last;

  logic [1:0]          in_op;
  logic [NowW-1:0]     in_now;
  logic [TmoW-1:0]     in_tmo;
  logic [SeqW-1:0]     in_sq;
  logic [AckWin-1:0]   in_bits;

  assign in_op   = s_axis_tuser;
  assign in_now  = s_axis_tdata[30:0];
  assign in_tmo  = s_axis_tdata[46:31];
  assign in_sq   = s_axis_tdata[62:47];
  assign in_bits = s_axis_tdata[94:63];

  assign out_free      = !ov_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // apb
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'd0, thr_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 8'd3;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      thr_q <= pwdata[7:0];
    end
  end

  // remote window update
  logic [SeqW-1:0] rd_dist, rd_dm1, rd_back;
  always_comb begin
    nrs_d   = nrs_q;
    win_d   = win_q;
    seen_d  = seen_q;
    rd_dist = in_sq - nrs_q;
    rd_dm1  = rd_dist - SeqW'(1);
    rd_back = nrs_q - SeqW'(1) - in_sq;
    if (accept && in_op == OP_RECV) begin
      if (!seen_q) begin
        seen_d = 1'b1;
        nrs_d  = in_sq;
        win_d  = '0;
      end else if (rd_dist == '0) begin
        win_d = win_q;
      end else if (seq_newer(in_sq, nrs_q)) begin
        win_d = (rd_dist < SeqW'(AckWin)) ? (win_q << rd_dist[WinIdxW-1:0]) : '0;
        if (rd_dm1 < SeqW'(AckWin)) win_d[rd_dm1[WinIdxW-1:0]] = 1'b1;
        nrs_d = in_sq;
      end else if (rd_back < SeqW'(AckWin)) begin
        win_d[rd_back[WinIdxW-1:0]] = 1'b1;
      end
    end
  end

  // ack evaluation of the entry just read
  logic [SeqW-1:0]  ak_idx;
  logic [MissW-1:0] ak_miss;
  logic [1:0]       ak_kind;
  logic             tk_expired;
  always_comb begin
    ak_idx  = sq_q - SeqW'(1) - rd_q.seq;
    ak_miss = rd_q.misses;
    ak_kind = EV_NONE;
    if (!seq_newer(rd_q.seq, sq_q)) begin
      if (rd_q.seq == sq_q) begin
        ak_kind = EV_ACKED;
      end else if (ak_idx < SeqW'(AckWin)) begin
        if (bits_q[ak_idx[WinIdxW-1:0]]) begin
          ak_kind = EV_ACKED;
        end else begin
          if (rd_q.misses != '1) ak_miss = rd_q.misses + MissW'(1);
          if (ak_miss >= thr_q) ak_kind = EV_LOST;
        end
      end
    end
    tk_expired = {1'b0, now_q} >= rd_q.deadline;
  end

  always_comb begin
    state_d    = state_q;
    next_seq_d = next_seq_q;
    head_d     = head_q;
    cnt_d      = cnt_q;
    r_d        = r_q;
    w_d        = w_q;
    we         = 1'b0;
    waddr      = head_q + cnt_q[PendIdxW-1:0];
    wdata      = '{seq: next_seq_q, misses: '0,
                   deadline: {1'b0, in_now} + {16'd0, in_tmo}};
    raddr      = head_q + r_q[PendIdxW-1:0];
    emit       = 1'b0;
    emit_kind  = EV_NONE;
    emit_seq   = '0;
    emit_last  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        r_d = '0;
        w_d = '0;
        if (accept) begin
          case (in_op)
            OP_SENT: begin
              emit     = 1'b1;
              emit_seq = next_seq_q;
              if (cnt_q == PendCntW'(PendDepth)) begin
                emit_kind = EV_FULL;
              end else begin
                we         = 1'b1;
                cnt_d      = cnt_q + PendCntW'(1);
                next_seq_d = next_seq_q + SeqW'(1);
              end
            end
            OP_RECV: emit = 1'b1;
            default: state_d = (cnt_q == '0) ? ST_END : ST_RD;
          endcase
        end
      end
      ST_RD: state_d = ST_EV;
      ST_EV: begin
        emit_last = 1'b0;
        if (op_q == OP_ACK) begin
          emit_kind = ak_kind;
          emit_seq  = rd_q.seq;
          if (ak_kind == EV_NONE || out_free) begin
            emit = ak_kind != EV_NONE;
            if (ak_kind == EV_NONE) begin
              // keep entry, compacted toward the head
              we    = 1'b1;
              waddr = head_q + w_q[PendIdxW-1:0];
              wdata = '{seq: rd_q.seq, misses: ak_miss, deadline: rd_q.deadline};
              w_d   = w_q + PendCntW'(1);
            end
            r_d     = r_q + PendCntW'(1);
            state_d = (r_q + PendCntW'(1) == cnt_q) ? ST_END : ST_RD;
          end
        end else begin
          emit_kind = EV_LOST;
          emit_seq  = rd_q.seq;
          if (!tk_expired) begin
            state_d = ST_END;
          end else if (out_free) begin
            emit    = 1'b1;
            head_d  = head_q + PendIdxW'(1);
            cnt_d   = cnt_q - PendCntW'(1);
            state_d = (cnt_q == PendCntW'(1)) ? ST_END : ST_RD;
          end
        end
      end
      default: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = ST_IDLE;
          if (op_q == OP_ACK) cnt_d = w_q;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      next_seq_q <= '0;
      head_q     <= '0;
      cnt_q      <= '0;
      r_q        <= '0;
      w_q        <= '0;
      nrs_q      <= '0;
      win_q      <= '0;
      seen_q     <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      next_seq_q <= next_seq_d;
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      r_q        <= r_d;
      w_q        <= w_d;
      nrs_q      <= nrs_d;
      win_q      <= win_d;
      seen_q     <= seen_d;
      if (emit) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_op;
      now_q  <= in_now;
      sq_q   <= in_sq;
      bits_q <= in_bits;
    end
    if (emit) begin
      okind_q     <= emit_kind;
      oseq_q      <= emit_seq;
      olast_q     <= emit_last;
      oremseq_q   <= nrs_d;
      orembits_q  <= win_d;
      oremvalid_q <= seen_d;
    end
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {7'd0, oremvalid_q, orembits_q, oremseq_q, oseq_q};

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PendCntW'(PendDepth)) else $error("pending count overflow");
  a_compact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    w_q <= r_q) else $error("write index passed read index");
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EV) |-> (r_q < cnt_q)) else $error("walk beyond table");
  a_no_lost_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_axis_tready) |-> !emit) else $error("result overwritten");
`endif

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import pat_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [15:0] seq;
    logic        last;
    logic [15:0] rseq;
    logic [31:0] rbits;
    logic        rvalid;
  } ack_event_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  packet_ack_tracker_top dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  localparam logic [2:0] ADDR_LOST_THR = 3'd0;

  // predictor state
  logic [7:0]  lost_thr;
  logic [15:0] local_seq;
  int          pend_cnt;
  logic [15:0] pend_seq [PendDepth];
  logic [7:0]  pend_miss [PendDepth];
  logic [31:0] pend_dl [PendDepth];
  logic [15:0] newest_rseq;
  logic        rseen;
  logic [31:0] rwin;

  ack_event_t expected_events[$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  int cycles = 0;
  localparam int CycleLimit = 2000000;

  function automatic logic newer(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return (d != 0) && ((d < 16'h8000) || ((d == 16'h8000) && (a > b)));
  endfunction

  function automatic void push_event(logic [1:0] kind, logic [15:0] seq, logic last);
    ack_event_t e;
    e.kind = kind; e.seq = seq; e.last = last;
    e.rseq = newest_rseq; e.rbits = rwin; e.rvalid = rseen;
    expected_events.push_back(e);
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < pend_cnt; i++) begin
      pend_seq[i] = pend_seq[i+1];
      pend_miss[i] = pend_miss[i+1];
      pend_dl[i] = pend_dl[i+1];
    end
    pend_cnt--;
  endfunction

  function automatic void predict_tracker(logic [1:0] op, logic [30:0] now,
                                          logic [15:0] tmo, logic [15:0] sq,
                                          logic [31:0] bits);
    logic [15:0] d;
    logic [15:0] idx;
    logic [1:0]  kind;
    int i;
    case (op)
      OP_SENT: begin
        if (pend_cnt >= PendDepth) begin
          push_event(EV_FULL, local_seq, 1'b1);
        end else begin
          pend_seq[pend_cnt] = local_seq;
          pend_miss[pend_cnt] = '0;
          pend_dl[pend_cnt] = {1'b0, now} + {16'b0, tmo};
          pend_cnt++;
          push_event(EV_NONE, local_seq, 1'b1);
          local_seq++;
        end
      end
      OP_RECV: begin
        if (!rseen) begin
          rseen = 1'b1; newest_rseq = sq; rwin = '0;
        end else begin
          d = sq - newest_rseq;
          if (d != 0) begin
            if (newer(sq, newest_rseq)) begin
              rwin = (d < 32) ? (rwin << d) : '0;
              if (d <= 32) rwin[d-1] = 1'b1;
              newest_rseq = sq;
            end else begin
              idx = newest_rseq - 16'd1 - sq;
              if (idx < 32) rwin[idx] = 1'b1;
            end
          end
        end
        push_event(EV_NONE, 16'd0, 1'b1);
      end
      OP_ACK: begin
        i = 0;
        while (i < pend_cnt) begin
          kind = EV_NONE;
          if (!newer(pend_seq[i], sq)) begin
            if (pend_seq[i] == sq) kind = EV_ACKED;
            else begin
              idx = sq - 16'd1 - pend_seq[i];
              if (idx < 32) begin
                if (bits[idx]) kind = EV_ACKED;
                else begin
                  if (pend_miss[i] != 8'hff) pend_miss[i]++;
                  if (pend_miss[i] >= lost_thr) kind = EV_LOST;
                end
              end
            end
          end
          if (kind != EV_NONE) begin
            push_event(kind, pend_seq[i], 1'b0);
            drop_entry(i);
          end else begin
            i++;
          end
        end
        push_event(EV_NONE, 16'd0, 1'b1);
      end
      default: begin
        while (pend_cnt > 0 && {1'b0, now} >= pend_dl[0]) begin
          push_event(EV_LOST, pend_seq[0], 1'b0);
          drop_entry(0);
        end
        push_event(EV_NONE, 16'd0, 1'b1);
      end
    endcase
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** packet_ack_tracker_top: FAILED **");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    ack_event_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", m_axis_tdata);
      end else begin
        e = expected_events.pop_front();
        if (m_axis_tuser !== e.kind || m_axis_tdata[15:0] !== e.seq
            || m_axis_tlast !== e.last || m_axis_tdata[31:16] !== e.rseq
            || m_axis_tdata[63:32] !== e.rbits || m_axis_tdata[64] !== e.rvalid) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp kind %0d seq %h last %b rseq %h rbits %h rv %b,",
                      " got %0d %h %b %h %h %b"},
                     e.kind, e.seq, e.last, e.rseq, e.rbits, e.rvalid, m_axis_tuser,
                     m_axis_tdata[15:0], m_axis_tlast, m_axis_tdata[31:16],
                     m_axis_tdata[63:32], m_axis_tdata[64]);
        end
      end
    end
  end

  task automatic send_item(logic [1:0] op, logic [30:0] now, logic [15:0] tmo,
                           logic [15:0] sq, logic [31:0] bits);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {1'b0, bits, sq, tmo, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_tracker(op, now, tmo, sq, bits);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_lost_thr(logic [7:0] value);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_LOST_THR; pwdata <= {24'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    lost_thr = value;
  endtask

  task automatic test_directed;
    send_item(OP_ACK, 31'd0, 16'd0, 16'd0, 32'd0);
    send_item(OP_TICK, 31'h7fffffff, 16'd0, 16'd0, 32'd0);
    send_item(OP_RECV, 31'd0, 16'd0, 16'hffff, 32'd0);
    send_item(OP_RECV, 31'd0, 16'd0, 16'hffff, 32'd0);
    send_item(OP_RECV, 31'd0, 16'd0, 16'd2, 32'd0);
    send_item(OP_RECV, 31'd0, 16'd0, 16'd0, 32'd0);
    send_item(OP_RECV, 31'd0, 16'd0, 16'h8002, 32'd0);
    send_item(OP_RECV, 31'd0, 16'd0, 16'h0100, 32'd0);
    send_item(OP_RECV, 31'd0, 16'd0, 16'h0050, 32'd0);
    for (int i = 0; i < 34; i++)
      send_item(OP_SENT, 31'h7fffffff, 16'hffff, 16'd0, 32'd0);
    send_item(OP_ACK, 31'd0, 16'd0, 16'd5, 32'h0000_000a);
    send_item(OP_ACK, 31'd0, 16'd0, 16'd40, 32'hffff_fff0);
    send_item(OP_ACK, 31'd0, 16'd0, 16'd40, 32'd0);
    send_item(OP_ACK, 31'd0, 16'd0, 16'h8010, 32'hffff_ffff);
    send_item(OP_TICK, 31'h7fffffff, 16'd0, 16'd0, 32'd0);
    send_item(OP_TICK, 31'h7fffffff, 16'd0, 16'd0, 32'd0);
    send_item(OP_SENT, 31'd1000, 16'd0, 16'd0, 32'd0);
    send_item(OP_TICK, 31'd999, 16'd0, 16'd0, 32'd0);
    send_item(OP_TICK, 31'd1000, 16'd0, 16'd0, 32'd0);
  endtask

  // random sent/recv/ack/tick items, ack and recv sequences mostly near the live sequence numbers
  task automatic test_random(int n_items);
    logic [1:0]  op;
    logic [15:0] sq;
    logic [30:0] now;
    for (int n = 0; n < n_items; n++) begin
      op = 2'($urandom_range(3));
      now = ($urandom_range(9) == 0) ? 31'($urandom) : 31'($urandom_range(200000));
      if (op == OP_ACK && $urandom_range(3) != 0)
        sq = local_seq - 16'($urandom_range(40));
      else if (op == OP_RECV && $urandom_range(3) != 0)
        sq = newest_rseq + 16'($urandom_range(80)) - 16'd40;
      else
        sq = 16'($urandom);
      send_item(op, now, 16'($urandom), sq, $urandom);
    end
  endtask

  initial begin
    lost_thr = 8'd3; local_seq = '0; pend_cnt = 0;
    newest_rseq = '0; rseen = 1'b0; rwin = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 17; recv_idle_pct = 67;
    test_directed();
    write_lost_thr(8'd1);
    test_random(50);
    write_lost_thr(8'd255);
    send_idle_pct = 67; recv_idle_pct = 17;
    test_random(50);
    write_lost_thr(8'd2);
    test_random(50);
    send_idle_pct = 0; recv_idle_pct = 0;
    write_lost_thr(8'd0);
    test_random(30);
    write_lost_thr(8'd3);
    test_random(30);
    drain();
    if (mismatches == 0 && expected_events.size() == 0) begin
      $display("** packet_ack_tracker_top: PASSED **");
    end else begin
      $display("** packet_ack_tracker_top: FAILED **");
    end
    $finish;
  end

endmodule

@@ packet_ack_tracker_top.f @@
hdl/pat_pkg.sv
hdl/packet_ack_tracker_top.sv
tb/tb_top.sv
